// ===== hdl/exq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exq_pkg
// Shared types and constants for the Euler xyz to quaternion block.
// ----------------------------------------------------------------------------
package exq_pkg;

   localparam int AngleW = 17;
   localparam int QuatW = 16;
   localparam int SeriesSteps = 5;
   localparam int LaneStages = 2 * SeriesSteps + 5;
   localparam int MergeStages = 3;

   localparam logic [16:0] Deg90 = 17'd46080;
   localparam logic [17:0] Deg180 = 18'd92160;
   localparam logic [16:0] Deg45 = 17'd23040;
   localparam logic [31:0] PiQ30 = 32'd3373259426;
   localparam logic [30:0] Q30One = 31'h40000000;

   typedef struct packed {
      logic signed [QuatW-1:0] s;
      logic signed [QuatW-1:0] c;
   } sincos_type;

endpackage : exq_pkg
`default_nettype wire

// ===== hdl/exq_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exq_lane
// Pipelined half-angle sine and cosine of one axis, Taylor series in Q30.
// ----------------------------------------------------------------------------
module exq_lane
   import exq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     advance,
   input  wire logic signed [AngleW-1:0] angle,
   output sincos_type                    result
);

   localparam logic [15:0] PiQuot = 16'(PiQ30 / 32'(Deg180));
   localparam logic [14:0] PiRem = 15'(PiQ30 - 32'(PiQuot) * 32'(Deg180));
   localparam logic [18:0] Recip45 = 19'(((64'd1 << 24) + 64'd44) / 64'd45);
   localparam logic [30:0] R72 = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
   localparam logic [30:0] R90 = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
   localparam logic [30:0] R42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [30:0] R20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [30:0] R6 = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [30:0] R56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [30:0] R30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [30:0] R12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

   // Stage 0: fold the angle
   logic [16:0] m0_ff, m0_in;
   logic        neg0_ff, cneg0_ff, swap0_ff, cneg0_in, swap0_in;
   logic [17:0] mag;
   logic [16:0] mf;

   always_comb begin
      mag = angle[AngleW-1] ? 18'(-$signed({angle[AngleW-1], angle})) : 18'(angle);
      cneg0_in = mag > 18'(Deg90);
      mf = cneg0_in ? 17'(Deg180 - mag) : mag[16:0];
      swap0_in = mf > Deg45;
      m0_in = swap0_in ? 17'(Deg90 - mf) : mf;
   end

   // Stage 1: scale to radians, split into whole and fractional parts of 92160
   logic [30:0] ma1_ff;
   logic [28:0] nb1_ff;
   logic        neg1_ff, cneg1_ff, swap1_ff;

   // Stage 2: divide the fractional part by 92160 with a reciprocal multiply
   logic [30:0] x2s_ff;
   logic        neg2_ff, cneg2_ff, swap2_ff;

   // Stage 3: square
   logic [61:0] sq3_ff;
   logic [30:0] x3_ff;
   logic        neg3_ff, cneg3_ff, swap3_ff;

   // Series pipeline: five steps, each a multiply stage then a divide stage
   localparam int Steps = SeriesSteps;
   logic [30:0] x2v_ff [0:2*Steps];
   logic [30:0] xv_ff  [0:2*Steps];
   logic [30:0] ts_ff  [0:2*Steps];
   logic [30:0] tc_ff  [0:2*Steps];
   logic [61:0] ps_ff  [0:2*Steps];
   logic [61:0] pc_ff  [0:2*Steps];
   logic        ng_ff  [0:2*Steps];
   logic        cn_ff  [0:2*Steps];
   logic        sw_ff  [0:2*Steps];

   function automatic logic [30:0] mul_shr(input logic [30:0] v, input logic [30:0] r,
                                           input int s);
      logic [61:0] p;
      p = 62'(v) * 62'(r);
      return 31'(p >> s);
   endfunction

   function automatic logic [30:0] sdiv(input logic [30:0] v, input int k);
      logic [30:0] r;
      case (k)
         0: r = mul_shr(v, R42, 36);
         1: r = mul_shr(v, R20, 35);
         2: r = mul_shr(v, R6, 33);
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   function automatic logic [30:0] cdiv(input logic [30:0] v, input int k);
      logic [30:0] r;
      case (k)
         0: r = mul_shr(v, R56, 36);
         1: r = mul_shr(v, R30, 35);
         2: r = mul_shr(v, R12, 34);
         3: r = v >> 1;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   logic [30:0] x2_3;
   assign x2_3 = sq3_ff[60:30];

   always_ff @(posedge clock) begin
      if (advance) begin
         m0_ff <= m0_in;
         neg0_ff <= angle[AngleW-1];
         cneg0_ff <= cneg0_in;
         swap0_ff <= swap0_in;

         ma1_ff <= 31'(m0_ff) * 31'(PiQuot);
         nb1_ff <= 29'(m0_ff) * 29'(PiRem) + 29'(Deg90);
         neg1_ff <= neg0_ff;
         cneg1_ff <= cneg0_ff;
         swap1_ff <= swap0_ff;

         x2s_ff <= ma1_ff + 31'((37'(nb1_ff[28:11]) * 37'(Recip45)) >> 24);
         neg2_ff <= neg1_ff;
         cneg2_ff <= cneg1_ff;
         swap2_ff <= swap1_ff;

         sq3_ff <= 62'(x2s_ff) * 62'(x2s_ff);
         x3_ff <= x2s_ff;
         neg3_ff <= neg2_ff;
         cneg3_ff <= cneg2_ff;
         swap3_ff <= swap2_ff;

         x2v_ff[0] <= x2_3;
         xv_ff[0] <= x3_ff;
         ts_ff[0] <= Q30One - mul_shr(x2_3, R72, 37);
         tc_ff[0] <= Q30One - mul_shr(x2_3, R90, 37);
         ps_ff[0] <= '0;
         pc_ff[0] <= '0;
         ng_ff[0] <= neg3_ff;
         cn_ff[0] <= cneg3_ff;
         sw_ff[0] <= swap3_ff;

         for (int i = 0; i < Steps; i++) begin
            // multiply
            x2v_ff[2*i+1] <= x2v_ff[2*i];
            xv_ff[2*i+1] <= xv_ff[2*i];
            ts_ff[2*i+1] <= ts_ff[2*i];
            tc_ff[2*i+1] <= tc_ff[2*i];
            ps_ff[2*i+1] <= (i < 3) ? 62'(x2v_ff[2*i]) * 62'(ts_ff[2*i])
                                    : 62'(xv_ff[2*i]) * 62'(ts_ff[2*i]);
            pc_ff[2*i+1] <= 62'(x2v_ff[2*i]) * 62'(tc_ff[2*i]);
            ng_ff[2*i+1] <= ng_ff[2*i];
            cn_ff[2*i+1] <= cn_ff[2*i];
            sw_ff[2*i+1] <= sw_ff[2*i];
            // divide and subtract, or carry the term through
            x2v_ff[2*i+2] <= x2v_ff[2*i+1];
            xv_ff[2*i+2] <= xv_ff[2*i+1];
            if (i < 3)
               ts_ff[2*i+2] <= Q30One - sdiv(ps_ff[2*i+1][60:30], i);
            else if (i == 3)
               ts_ff[2*i+2] <= ps_ff[2*i+1][60:30];
            else
               ts_ff[2*i+2] <= ts_ff[2*i+1];
            if (i < 4)
               tc_ff[2*i+2] <= Q30One - cdiv(pc_ff[2*i+1][60:30], i);
            else
               tc_ff[2*i+2] <= tc_ff[2*i+1];
            ps_ff[2*i+2] <= ps_ff[2*i+1];
            pc_ff[2*i+2] <= pc_ff[2*i+1];
            ng_ff[2*i+2] <= ng_ff[2*i+1];
            cn_ff[2*i+2] <= cn_ff[2*i+1];
            sw_ff[2*i+2] <= sw_ff[2*i+1];
         end
      end
   end

   logic [30:0] s30, c30, sv, cv;
   logic [15:0] s14, c14;
   always_comb begin
      s30 = ts_ff[2*Steps];
      c30 = tc_ff[2*Steps];
      sv = sw_ff[2*Steps] ? c30 : s30;
      cv = sw_ff[2*Steps] ? s30 : c30;
      s14 = 16'((32'(sv) + 32'd32768) >> 16);
      c14 = 16'((32'(cv) + 32'd32768) >> 16);
      result.s = ng_ff[2*Steps] ? -$signed(s14) : $signed(s14);
      result.c = cn_ff[2*Steps] ? -$signed(c14) : $signed(c14);
   end

endmodule : exq_lane
`default_nettype wire

// ===== hdl/exq_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exq_merge
// Hamilton product of the three axis quaternions, rounding and saturation.
// ----------------------------------------------------------------------------
module exq_merge
   import exq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       advance,
   input  sincos_type      ax,
   input  sincos_type      ay,
   input  sincos_type      az,
   output logic signed [QuatW-1:0] quat_w,
   output logic signed [QuatW-1:0] quat_x,
   output logic signed [QuatW-1:0] quat_y,
   output logic signed [QuatW-1:0] quat_z
);

   logic signed [31:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [15:0] sz_ff, cz_ff;
   logic signed [47:0] t_ff [0:7];

   function automatic logic signed [15:0] rnd(input logic signed [48:0] v);
      logic signed [48:0] r;
      r = (v + 49'sd134217728) >>> 28;
      if (r > 49'sd16384) r = 49'sd16384;
      if (r < -49'sd16384) r = -49'sd16384;
      return 16'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff <= ax.c * ay.c;
         p1_ff <= ax.s * ay.c;
         p2_ff <= ax.c * ay.s;
         p3_ff <= ax.s * ay.s;
         sz_ff <= az.s;
         cz_ff <= az.c;
         t_ff[0] <= p0_ff * cz_ff;
         t_ff[1] <= p3_ff * sz_ff;
         t_ff[2] <= p1_ff * cz_ff;
         t_ff[3] <= p2_ff * sz_ff;
         t_ff[4] <= p2_ff * cz_ff;
         t_ff[5] <= p1_ff * sz_ff;
         t_ff[6] <= p0_ff * sz_ff;
         t_ff[7] <= p3_ff * cz_ff;
         quat_w <= rnd(49'(t_ff[0]) - 49'(t_ff[1]));
         quat_x <= rnd(49'(t_ff[2]) + 49'(t_ff[3]));
         quat_y <= rnd(49'(t_ff[4]) - 49'(t_ff[5]));
         quat_z <= rnd(49'(t_ff[6]) + 49'(t_ff[7]));
      end
   end

endmodule : exq_merge
`default_nettype wire

// ===== hdl/euler_xyz_to_quaternion_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_xyz_to_quaternion_top
// Three angle lanes feed a Hamilton product merge; one beat per cycle.
// ----------------------------------------------------------------------------
// Accepts one beat per clock and returns the quaternion through the lane series
// pipeline and the three-stage merge. The whole pipeline stalls while the
// output beat is not taken.
module euler_xyz_to_quaternion_top
   import exq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [AngleW-1:0] req_angle_x,
   input  wire logic signed [AngleW-1:0] req_angle_y,
   input  wire logic signed [AngleW-1:0] req_angle_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [QuatW-1:0]       rsp_quat_w,
   output logic signed [QuatW-1:0]       rsp_quat_x,
   output logic signed [QuatW-1:0]       rsp_quat_y,
   output logic signed [QuatW-1:0]       rsp_quat_z
);

   localparam int Depth = LaneStages + MergeStages;
   logic [Depth-1:0] vld_ff, vld_in;
   logic advance;
   sincos_type rx, ry, rz;

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[Depth-1];

   always_comb begin
      vld_in = vld_ff;
      if (advance) vld_in = {vld_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   exq_lane u_lx (.clock, .advance, .angle(req_angle_x), .result(rx));
   exq_lane u_ly (.clock, .advance, .angle(req_angle_y), .result(ry));
   exq_lane u_lz (.clock, .advance, .angle(req_angle_z), .result(rz));

   exq_merge u_merge (
      .clock, .advance, .ax(rx), .ay(ry), .az(rz),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y), .quat_z(rsp_quat_z)
   );

endmodule : euler_xyz_to_quaternion_top
`default_nettype wire

// ===== tb/tb_euler_xyz_to_quaternion_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_xyz_to_quaternion_top
// Checks the Euler xyz to quaternion block beat by beat. The testbench starts
// with a table of directed angles, some with hand-worked quaternions, then
// sends random angles. Each accepted beat without a hand-worked quaternion is
// predicted by an integer half-angle series and a Hamilton product. Both
// handshakes idle at random, and one long output stall backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_euler_xyz_to_quaternion_top;
   import exq_pkg::*;

   localparam int NumRandom = 1300;
   localparam int WatchLimit = 3000;
   localparam int HoldCycles = 300;
   localparam logic signed [AngleW-1:0] A90 = 17'sd46080;
   localparam logic signed [QuatW-1:0] One = 16'sd16384;

   typedef struct {
      logic signed [QuatW-1:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [AngleW-1:0] ax, ay, az;
      bit                       known;
      quat_type                 q;
   } angle_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [AngleW-1:0] req_angle_x = '0;
   logic signed [AngleW-1:0] req_angle_y = '0;
   logic signed [AngleW-1:0] req_angle_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [QuatW-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type quat_pending[$];
   bit       row_known = 1'b0;
   quat_type row_quat;
   bit       idle_on = 1'b1;
   bit       hold_go = 1'b0;
   int       mismatches = 0;
   int       quiet_cycles = 0;

   always #10 clock = ~clock;

   euler_xyz_to_quaternion_top dut (.*);

   function automatic sincos_type half_sin_cos(logic signed [AngleW-1:0] a);
      longint unsigned m, x, x2, t, s30, c30, sv, cv;
      bit neg, cneg, swap;
      longint s14, c14;
      sincos_type r;
      neg = a < 0;
      m = neg ? longint'(-longint'(a)) : longint'(a);
      cneg = 1'b0;
      swap = 1'b0;
      if (m > 46080) begin
         m = 92160 - m;
         cneg = 1'b1;
      end
      if (m > 23040) begin
         m = 46080 - m;
         swap = 1'b1;
      end
      x = (m * 64'd3373259426 + 46080) / 92160;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s30 = (x * t) >> 30;
      t = (64'd1 << 30) - x2 / 90;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 56;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
      c30 = t;
      sv = swap ? c30 : s30;
      cv = swap ? s30 : c30;
      s14 = longint'((sv + 32768) >> 16);
      c14 = longint'((cv + 32768) >> 16);
      r.s = 16'(neg ? -s14 : s14);
      r.c = 16'(cneg ? -c14 : c14);
      return r;
   endfunction

   function automatic logic signed [QuatW-1:0] q42_round(longint v);
      longint r;
      r = (v + (longint'(1) <<< 27)) >>> 28;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[QuatW-1:0];
   endfunction

   function automatic quat_type euler_to_quat(logic signed [AngleW-1:0] ax,
                                              logic signed [AngleW-1:0] ay,
                                              logic signed [AngleW-1:0] az);
      sincos_type hx, hy, hz;
      longint p0, p1, p2, p3, sz, cz;
      quat_type q;
      hx = half_sin_cos(ax);
      hy = half_sin_cos(ay);
      hz = half_sin_cos(az);
      p0 = longint'(hx.c) * longint'(hy.c);
      p1 = longint'(hx.s) * longint'(hy.c);
      p2 = longint'(hx.c) * longint'(hy.s);
      p3 = longint'(hx.s) * longint'(hy.s);
      sz = longint'(hz.s);
      cz = longint'(hz.c);
      q.w = q42_round(p0 * cz - p3 * sz);
      q.x = q42_round(p1 * cz + p2 * sz);
      q.y = q42_round(p2 * cz - p1 * sz);
      q.z = q42_round(p0 * sz + p3 * cz);
      return q;
   endfunction

   task automatic send_angles(logic signed [AngleW-1:0] ax, logic signed [AngleW-1:0] ay,
                              logic signed [AngleW-1:0] az);
      while (idle_on && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic signed [AngleW-1:0] rand_angle();
      int k;
      k = $urandom_range(99);
      if (k < 70) return 17'($signed($urandom_range(92160)) - 46080);
      if (k < 90) return 17'($urandom);
      return (k < 95) ? 17'sh0FFFF : 17'sh10000;
   endfunction

   always @(posedge clock) begin
      quat_type e;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WatchLimit) begin
            $display("euler_xyz_to_quaternion_top test failed");
            $finish;
         end
         if (req_valid && req_ready)
            quat_pending.push_back(row_known ? row_quat :
                                   euler_to_quat(req_angle_x, req_angle_y, req_angle_z));
         if (rsp_valid && rsp_ready) begin
            if (quat_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat w=%0d", rsp_quat_w);
            end else begin
               e = quat_pending.pop_front();
               if (e.w !== rsp_quat_w || e.x !== rsp_quat_x || e.y !== rsp_quat_y ||
                   e.z !== rsp_quat_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                              e.w, e.x, e.y, e.z,
                              rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               end
            end
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_go) begin
            hold_go = 1'b0;
            n = 0;
            rsp_ready <= 1'b0;
            while (n < HoldCycles) begin
               @(posedge clock);
               n++;
            end
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < 11);
         @(posedge clock);
      end
   end

   initial begin
      angle_row_type rows[$];
      quat_type ident, qx, qy, qz, qnx;
      ident = '{One, 0, 0, 0};
      qx = '{0, One, 0, 0};
      qy = '{0, 0, One, 0};
      qz = '{0, 0, 0, One};
      qnx = '{0, -One, 0, 0};
      rows.push_back('{0, 0, 0, 1'b1, ident});
      rows.push_back('{A90, 0, 0, 1'b1, qx});
      rows.push_back('{0, A90, 0, 1'b1, qy});
      rows.push_back('{0, 0, A90, 1'b1, qz});
      rows.push_back('{-A90, 0, 0, 1'b1, qnx});
      rows.push_back('{-A90, -A90, -A90, 1'b0, ident});
      rows.push_back('{A90, A90, A90, 1'b0, ident});
      rows.push_back('{17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF, 1'b0, ident});
      rows.push_back('{17'sh10000, 17'sh10000, 17'sh10000, 1'b0, ident});
      rows.push_back('{17'sh0FFFF, 17'sh10000, 0, 1'b0, ident});
      rows.push_back('{23040, 23040, 23040, 1'b0, ident});
      rows.push_back('{23041, -23039, 23040, 1'b0, ident});
      rows.push_back('{46081, -46081, 46079, 1'b0, ident});
      rows.push_back('{11520, 34560, -11520, 1'b0, ident});
      rows.push_back('{1, -1, 1, 1'b0, ident});
      rows.push_back('{-1, 17'sh1FFFF, 2, 1'b0, ident});
      rows.push_back('{0, 0, 17'sh10000, 1'b0, ident});
      rows.push_back('{23040, A90, -23040, 1'b0, ident});
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         row_known <= rows[i].known;
         row_quat <= rows[i].q;
         send_angles(rows[i].ax, rows[i].ay, rows[i].az);
      end
      row_known <= 1'b0;
      for (int i = 0; i < NumRandom; i++) begin
         idle_on = !(i >= 400 && i < 700);
         if (i == 800) hold_go = 1'b1;
         if (i == 1000) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (quat_pending.size() == 0);
            @(posedge clock);
         end
         send_angles(rand_angle(), rand_angle(), rand_angle());
      end
      req_valid <= 1'b0;
      wait (quat_pending.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && quat_pending.size() == 0)
         $display("euler_xyz_to_quaternion_top test passed");
      else
         $display("euler_xyz_to_quaternion_top test failed");
      $finish;
   end

endmodule
